### src/swd_pkg.sv
// Shared types, widths and constants for the steered-vehicle wheel speed block.
package swd_pkg;

  localparam int SPEED_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int ANGLE_BITS      = 16;
  localparam int CORDIC_STEPS    = 30;

  // CORDIC x/y/z word, Q30 with headroom
  localparam int XY_W = 33;
  // rounded cos/sin, Q16
  localparam int CS_W = 19;
  // L*c, T*s and the numerators built from them
  localparam int MUL_W = 34;
  // divisor width
  localparam int DIV_W = 32;
  localparam int PROD_W = SPEED_BITS + MUL_W;
  localparam int MAG_W  = PROD_W + 1;
  localparam int REM_W  = DIV_W + SPEED_BITS;

  localparam int ANG_Q30_W = ANGLE_BITS + 30 - ANGLE_FRAC_BITS;
  localparam int AEXT_W    = (ANG_Q30_W > XY_W) ? ANG_Q30_W : XY_W;

  // front stage, CORDIC cells, four arithmetic stages, one divider cell per quotient bit
  localparam int ST_R1      = CORDIC_STEPS + 1;
  localparam int ST_R2      = CORDIC_STEPS + 2;
  localparam int ST_R3      = CORDIC_STEPS + 3;
  localparam int ST_R4      = CORDIC_STEPS + 4;
  localparam int PIPE_DEPTH = CORDIC_STEPS + 4 + SPEED_BITS;

  localparam longint HALF_PI_Q30     = 64'sd1686629713;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TREAD       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 2'd3;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] steer_angle;
    logic signed [SPEED_BITS-1:0] speed;
  } swd_in_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;
    logic                         saturated;
  } swd_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [DIV_W-1:0]      dvs;
    logic [SPEED_BITS-1:0] quo;
    logic                  neg;
    logic                  ovf;
  } div_t;

  // per-item side data traveling alongside the datapath
  typedef struct packed {
    logic signed [SPEED_BITS-1:0] speed;
    logic                         straight;
    logic                         ang_pos;
    logic                         pass;
  } tag_t;

  // truncated Q30 arctangent of 2^-i
  function automatic logic signed [XY_W-1:0] atan_q30(input int unsigned i);
    logic signed [XY_W-1:0] r;
    case (i)
      0:  r = 33'sd843314856;
      1:  r = 33'sd497837829;
      2:  r = 33'sd263043836;
      3:  r = 33'sd133525158;
      4:  r = 33'sd67021686;
      5:  r = 33'sd33543515;
      6:  r = 33'sd16775850;
      7:  r = 33'sd8388437;
      8:  r = 33'sd4194282;
      9:  r = 33'sd2097149;
      10: r = 33'sd1048575;
      11: r = 33'sd524287;
      12: r = 33'sd262143;
      13: r = 33'sd131071;
      14: r = 33'sd65535;
      15: r = 33'sd32767;
      16: r = 33'sd16383;
      17: r = 33'sd8191;
      18: r = 33'sd4095;
      19: r = 33'sd2047;
      20: r = 33'sd1023;
      21: r = 33'sd511;
      22: r = 33'sd255;
      23: r = 33'sd127;
      24: r = 33'sd63;
      25: r = 33'sd31;
      26: r = 33'sd15;
      27: r = 33'sd7;
      28: r = 33'sd3;
      29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/swd_cordic_cell.sv
// One rotation step of the pipelined CORDIC.
module swd_cordic_cell import swd_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  logic signed [XY_W-1:0] dx, dy, ang;
  cordic_t cell_d, cell_q;

  always_comb begin
    dx = cell_i.y >>> Step;
    dy = cell_i.x >>> Step;
    ang = atan_q30(Step);
    if (!cell_i.z[XY_W-1]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### src/swd_div_cell.sv
// One quotient bit of the pipelined restoring divider.
module swd_div_cell import swd_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  div_t cell_i,
  output div_t cell_o
);

  logic [REM_W-1:0] dsh;
  logic             ge;
  div_t             cell_d, cell_q;

  always_comb begin
    dsh = REM_W'(cell_i.dvs) << Bit;
    ge = (cell_i.rem >= dsh);
    cell_d = cell_i;
    if (ge) begin
      cell_d.rem = cell_i.rem - dsh;
      cell_d.quo = cell_i.quo | (SPEED_BITS'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### src/steer_differential_wheel_speed_core.sv
// Top level: rear wheel speeds from steering angle and speed.
//
// Input channel: in_valid_i / in_stall_o carry one command item (steering
// angle Q2.14 rad, speed Q4.12 m/s). Output channel: out_valid_o /
// out_stall_i carry one result item (left and right speeds, saturated flag).
// An item moves at an edge where valid is high and stall is low.
// Config channel: cfg_valid_i / cfg_ready_o with a register index and data;
// ready is always high. Write only while no item is in flight.
// From acceptance to out_valid_o an item passes a front stage, 30 CORDIC
// cells, four multiply/select stages, one divider cell per quotient bit,
// then the output register. Throughput: one item per cycle while the pipe
// is not frozen; every cell then takes a new item each clock.
// A stalled result sits in the output register and the pipe keeps moving;
// the next result lands in a skid register, and only while that is full
// does the pipe freeze and in_stall_o go high.
// Reset clears all valid flags and loads the configuration defaults
// (automatic mode, wheelbase 1460 mm, tread 1000 mm, dead band 16).
module steer_differential_wheel_speed_core import swd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  swd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output swd_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration
  logic        manual_q;
  logic [11:0] wheelbase_q, tread_q;
  logic [10:0] dead_band_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q    <= 1'b0;
      wheelbase_q <= 12'd1460;
      tread_q     <= 12'd1000;
      dead_band_q <= 11'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MANUAL_MODE: manual_q    <= cfg_data_i[0];
        CFG_WHEELBASE:   wheelbase_q <= cfg_data_i;
        CFG_TREAD:       tread_q     <= cfg_data_i;
        CFG_DEAD_BAND:   dead_band_q <= cfg_data_i[10:0];
        default:         manual_q    <= manual_q;
      endcase
    end
  end

  logic [11:0] l_eff, t_eff;
  assign l_eff = (wheelbase_q == '0) ? 12'd1 : wheelbase_q;
  assign t_eff = (tread_q == '0) ? 12'd1 : tread_q;

  // pipeline control
  logic                  en;
  logic [PIPE_DEPTH:0]   vld_q;
  tag_t                  tag_q [0:PIPE_DEPTH];
  logic                  skid_vld_q, out_vld_q;
  swd_out_t              skid_q, out_q;
  logic                  take;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign take       = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-1:0], in_valid_i};
    end
  end

  // front stage: dead band, Q30 angle, clamp
  logic signed [ANGLE_BITS:0]  ang_ext, ang_abs;
  logic signed [AEXT_W-1:0]    a_ext, a_clip;
  tag_t                        tag0;
  cordic_t                     cord0_d, cord0_q;
  cordic_t                     cord [0:CORDIC_STEPS];

  always_comb begin
    ang_ext = (ANGLE_BITS+1)'(in_data_i.steer_angle);
    ang_abs = ang_ext[ANGLE_BITS] ? -ang_ext : ang_ext;
    a_ext = AEXT_W'(in_data_i.steer_angle) <<< (30 - ANGLE_FRAC_BITS);
    if (a_ext > AEXT_W'(HALF_PI_Q30)) begin
      a_clip = AEXT_W'(HALF_PI_Q30);
    end else if (a_ext < -AEXT_W'(HALF_PI_Q30)) begin
      a_clip = -AEXT_W'(HALF_PI_Q30);
    end else begin
      a_clip = a_ext;
    end
    cord0_d.x = XY_W'(CORDIC_GAIN_Q30);
    cord0_d.y = '0;
    cord0_d.z = XY_W'(a_clip);
    tag0.speed    = in_data_i.speed;
    tag0.straight = $unsigned(ang_abs) < (ANGLE_BITS+1)'(dead_band_q);
    tag0.ang_pos  = !in_data_i.steer_angle[ANGLE_BITS-1] && (in_data_i.steer_angle != '0);
    tag0.pass     = 1'b0;
  end

  assign cord[0] = cord0_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    swd_cordic_cell #(.Step(k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (cord[k]),
      .cell_o (cord[k+1])
    );
  end

  // R1: round cos/sin, scale by lengths
  logic signed [CS_W-1:0]  c_r, s_r, s_abs;
  logic signed [MUL_W-1:0] lc_d, ts_d, tas_d, lc_q, ts_q, tas_q;

  always_comb begin
    c_r = CS_W'((cord[CORDIC_STEPS].x + XY_W'(8192)) >>> 14);
    s_r = CS_W'((cord[CORDIC_STEPS].y + XY_W'(8192)) >>> 14);
    s_abs = s_r[CS_W-1] ? -s_r : s_r;
    lc_d  = MUL_W'($signed({2'b00, l_eff, 1'b0})) * MUL_W'(c_r);
    ts_d  = MUL_W'($signed({1'b0, t_eff})) * MUL_W'(s_r);
    tas_d = MUL_W'($signed({1'b0, t_eff})) * MUL_W'(s_abs);
  end

  // R2: numerators and divisor per mode
  logic signed [MUL_W-1:0] num_a, den_a, n0_d, n1_d, n0_q, n1_q;
  logic [DIV_W-1:0]        d2_d, d2_q, d3_q;
  logic                    pass_d;

  always_comb begin
    num_a = lc_q - tas_q;
    den_a = lc_q + tas_q;
    if (manual_q) begin
      n0_d   = lc_q - ts_q;
      n1_d   = lc_q + ts_q;
      d2_d   = DIV_W'({l_eff, 17'b0});
      pass_d = 1'b0;
    end else begin
      n0_d   = num_a;
      n1_d   = num_a;
      d2_d   = DIV_W'(den_a);
      pass_d = den_a[MUL_W-1] || (den_a == '0);
    end
  end

  // R3: speed times numerator
  logic signed [PROD_W-1:0] p0_d, p1_d, p0_q, p1_q;
  assign p0_d = PROD_W'(tag_q[ST_R2].speed) * PROD_W'(n0_q);
  assign p1_d = PROD_W'(tag_q[ST_R2].speed) * PROD_W'(n1_q);

  // R4: magnitude, rounding offset, range check
  div_t             dv0 [0:SPEED_BITS];
  div_t             dv1 [0:SPEED_BITS];
  div_t             dv0_d, dv1_d, dv0_q, dv1_q;
  logic [PROD_W-1:0] mag0, mag1;
  logic [MAG_W-1:0]  m0, m1, lim;

  always_comb begin
    mag0 = p0_q[PROD_W-1] ? $unsigned(-p0_q) : $unsigned(p0_q);
    mag1 = p1_q[PROD_W-1] ? $unsigned(-p1_q) : $unsigned(p1_q);
    m0 = MAG_W'(mag0) + MAG_W'(d3_q >> 1);
    m1 = MAG_W'(mag1) + MAG_W'(d3_q >> 1);
    lim = MAG_W'({d3_q, SPEED_BITS'(0)});
    dv0_d.rem = REM_W'(m0);
    dv0_d.dvs = d3_q;
    dv0_d.quo = '0;
    dv0_d.neg = p0_q[PROD_W-1];
    dv0_d.ovf = (m0 >= lim);
    dv1_d.rem = REM_W'(m1);
    dv1_d.dvs = d3_q;
    dv1_d.quo = '0;
    dv1_d.neg = p1_q[PROD_W-1];
    dv1_d.ovf = (m1 >= lim);
  end

  assign dv0[0] = dv0_q;
  assign dv1[0] = dv1_q;

  for (genvar j = 0; j < SPEED_BITS; j++) begin : g_div
    swd_div_cell #(.Bit(SPEED_BITS - 1 - j)) u_lane0 (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (dv0[j]),
      .cell_o (dv0[j+1])
    );
    swd_div_cell #(.Bit(SPEED_BITS - 1 - j)) u_lane1 (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (dv1[j]),
      .cell_o (dv1[j+1])
    );
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      cord0_q <= cord0_d;
      lc_q    <= lc_d;
      ts_q    <= ts_d;
      tas_q   <= tas_d;
      n0_q    <= n0_d;
      n1_q    <= n1_d;
      d2_q    <= d2_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      d3_q    <= d2_q;
      dv0_q   <= dv0_d;
      dv1_q   <= dv1_d;
      tag_q[0] <= tag0;
      for (int k = 1; k <= PIPE_DEPTH; k++) begin
        if (k == ST_R2) begin
          tag_q[k] <= {tag_q[k-1].speed, tag_q[k-1].straight, tag_q[k-1].ang_pos, pass_d};
        end else begin
          tag_q[k] <= tag_q[k-1];
        end
      end
    end
  end

  // sign, saturate; result is {clip, value}
  function automatic logic [SPEED_BITS:0] lane_result(input div_t r);
    logic [SPEED_BITS-1:0] hi, lo;
    logic [SPEED_BITS:0]   res;
    hi = {1'b0, {(SPEED_BITS-1){1'b1}}};
    lo = {1'b1, {(SPEED_BITS-1){1'b0}}};
    if (r.ovf) begin
      res = {1'b1, r.neg ? lo : hi};
    end else if (r.neg) begin
      res = (r.quo > lo) ? {1'b1, lo} : {1'b0, -r.quo};
    end else begin
      res = (r.quo > hi) ? {1'b1, hi} : {1'b0, r.quo};
    end
    return res;
  endfunction

  logic [SPEED_BITS:0] res0, res1;
  logic [SPEED_BITS:0] inner;
  tag_t                tl;
  swd_out_t            res;

  always_comb begin
    tl = tag_q[PIPE_DEPTH];
    res0 = lane_result(dv0[SPEED_BITS]);
    res1 = lane_result(dv1[SPEED_BITS]);
    inner = tl.pass ? {1'b0, tl.speed} : res0;
    if (tl.straight) begin
      res.left_speed  = tl.speed;
      res.right_speed = tl.speed;
      res.saturated   = 1'b0;
    end else if (manual_q) begin
      res.left_speed  = res0[SPEED_BITS-1:0];
      res.right_speed = res1[SPEED_BITS-1:0];
      res.saturated   = res0[SPEED_BITS] | res1[SPEED_BITS];
    end else begin
      res.left_speed  = tl.ang_pos ? inner[SPEED_BITS-1:0] : tl.speed;
      res.right_speed = tl.ang_pos ? tl.speed : inner[SPEED_BITS-1:0];
      res.saturated   = inner[SPEED_BITS];
    end
  end

  // output register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en && vld_q[PIPE_DEPTH]) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q && take) begin
      skid_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[PIPE_DEPTH]) begin
      if (!out_vld_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (skid_vld_q && take) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // the skid only holds an item behind a waiting output
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> out_vld_q)
    else $error("skid full while output empty");

  // skid fills only when a result arrives behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i && vld_q[PIPE_DEPTH]))
    else $error("skid filled without a stalled result");

  // a frozen pipe keeps its valid flags
  assert property (@(posedge clk_i) disable iff (!rst_ni) !en |=> $stable(vld_q))
    else $error("pipe moved while frozen");

endmodule
